// ===== hw/rtl/rbst_pkg.sv =====
package rbst_pkg;

  // data path widths
  localparam int Q_W           = 32;
  localparam int FRAC_BITS_DEF = 16;

  // divider stages: magnitude stage, range stage, one stage per quotient bit, saturation
  localparam int DIV_LAT = Q_W + 3;

  typedef logic signed [Q_W-1:0] q_t;

  localparam q_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
  localparam q_t Q_ONE_LSB = q_t'(1);

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_MIN_X = 3'd0,
    CFG_MIN_Y = 3'd1,
    CFG_MIN_Z = 3'd2,
    CFG_MAX_X = 3'd3,
    CFG_MAX_Y = 3'd4,
    CFG_MAX_Z = 3'd5
  } cfg_idx_t;

  // per ray data that rides alongside the dividers
  typedef struct packed {
    q_t         near_limit;
    q_t         far_limit;
    logic       zero_miss;
    logic [2:0] dir_zero;
    logic [2:0] dir_neg;
  } side_t;

endpackage

// ===== hw/rtl/rbst_slab_div.sv =====
module rbst_slab_div #(
  parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          en,
  input  rbst_pkg::q_t  bound,
  input  rbst_pkg::q_t  orig,
  input  rbst_pkg::q_t  dir,
  output rbst_pkg::q_t  quot
);
  import rbst_pkg::*;

  localparam int DIFF_W = Q_W + 1;
  localparam int NUM_W  = DIFF_W + FRAC_BITS;

  // magnitude stage
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        a_mag_r;
  logic [Q_W-1:0]           a_dmag_r;
  logic                     a_neg_r;

  assign diff = {bound[Q_W-1], bound} - {orig[Q_W-1], orig};

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag_r  <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      a_dmag_r <= dir[Q_W-1] ? Q_W'(-dir) : Q_W'(dir);
      a_neg_r  <= diff[DIFF_W-1] ^ dir[Q_W-1];
    end
  end

  // range stage: quotient at or above 2^Q_W is flagged, remainder seeded
  logic [NUM_W-1:0]       num;
  logic [NUM_W-Q_W-1:0]   num_hi;
  logic [Q_W-1:0]         s_rem_r  [Q_W];
  logic [Q_W-1:0]         s_low_r  [Q_W];
  logic [Q_W-1:0]         s_q_r    [Q_W+1];
  logic [Q_W-1:0]         s_dmag_r [Q_W];
  logic                   s_neg_r  [Q_W+1];
  logic                   s_ovf_r  [Q_W+1];

  assign num    = {a_mag_r, {FRAC_BITS{1'b0}}};
  assign num_hi = num[NUM_W-1:Q_W];

  always_ff @(posedge clk) begin
    if (en) begin
      s_rem_r[0]  <= Q_W'(num_hi);
      s_low_r[0]  <= num[Q_W-1:0];
      s_q_r[0]    <= '0;
      s_dmag_r[0] <= a_dmag_r;
      s_neg_r[0]  <= a_neg_r;
      s_ovf_r[0]  <= Q_W'(num_hi) >= a_dmag_r;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < Q_W; k++) begin : g_bit
    logic [Q_W:0] trial;
    logic         ge;

    assign trial = {s_rem_r[k], s_low_r[k][Q_W-1]};
    assign ge    = trial >= {1'b0, s_dmag_r[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        s_q_r[k+1]    <= {s_q_r[k][Q_W-2:0], ge};
        s_neg_r[k+1]  <= s_neg_r[k];
        s_ovf_r[k+1]  <= s_ovf_r[k];
      end
    end

    if (k + 1 < Q_W) begin : g_low
      always_ff @(posedge clk) begin
        if (en) begin
          s_rem_r[k+1]  <= ge ? Q_W'(trial - {1'b0, s_dmag_r[k]}) : trial[Q_W-1:0];
          s_dmag_r[k+1] <= s_dmag_r[k];
          s_low_r[k+1]  <= {s_low_r[k][Q_W-2:0], 1'b0};
        end
      end
    end
  end

  // sign and saturation
  logic [Q_W-1:0] qm;
  q_t             dist_nxt;
  q_t             dist_r;

  assign qm = s_q_r[Q_W];

  always_comb begin
    if (!s_neg_r[Q_W]) begin
      dist_nxt = (s_ovf_r[Q_W] || qm[Q_W-1]) ? Q_MAX : q_t'(qm);
    end else if (s_ovf_r[Q_W] || (qm > Q_W'(Q_MIN))) begin
      dist_nxt = Q_MIN;
    end else begin
      dist_nxt = q_t'(-qm);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= dist_nxt;
    end
  end

  assign quot = dist_r;

endmodule

// ===== hw/rtl/ray_box_slab_test_core.sv =====
// Ray against axis-aligned box slab test, signed fixed point with FRAC_BITS fraction bits.
// Accepts one ray per clock while out_ready does not stall it and returns one result per
// ray, in order, through the divider stages, a window register and a result register. The
// six pipelined restoring dividers retire one quotient bit per stage; a stall on
// the result channel freezes the whole pipeline, so no ray is lost or repeated. The box
// is held in six registers written through the cfg channel (always ready) and resets to
// an empty box; write it only while no ray is in flight.
module ray_box_slab_test_core #(
  parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // configuration
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  rbst_pkg::q_t cfg_data,
  // ray input
  input  logic         in_valid,
  output logic         in_ready,
  input  rbst_pkg::q_t in_orig_x,
  input  rbst_pkg::q_t in_orig_y,
  input  rbst_pkg::q_t in_orig_z,
  input  rbst_pkg::q_t in_dir_x,
  input  rbst_pkg::q_t in_dir_y,
  input  rbst_pkg::q_t in_dir_z,
  input  rbst_pkg::q_t in_near_limit,
  input  rbst_pkg::q_t in_far_limit,
  // result
  output logic         out_valid,
  input  logic         out_ready,
  output logic         out_hit,
  output rbst_pkg::q_t out_hit_distance
);
  import rbst_pkg::*;

  // box registers
  q_t box_min_r [3];
  q_t box_max_r [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        box_min_r[a] <= Q_MAX;
        box_max_r[a] <= Q_MIN;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_X: box_min_r[0] <= cfg_data;
        CFG_MIN_Y: box_min_r[1] <= cfg_data;
        CFG_MIN_Z: box_min_r[2] <= cfg_data;
        CFG_MAX_X: box_max_r[0] <= cfg_data;
        CFG_MAX_Y: box_max_r[1] <= cfg_data;
        CFG_MAX_Z: box_max_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  q_t orig [3];
  q_t dir  [3];

  assign orig[0] = in_orig_x;
  assign orig[1] = in_orig_y;
  assign orig[2] = in_orig_z;
  assign dir[0]  = in_dir_x;
  assign dir[1]  = in_dir_y;
  assign dir[2]  = in_dir_z;

  // slab distance dividers
  q_t t_min [3];
  q_t t_max [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbst_slab_div #(.FRAC_BITS(FRAC_BITS)) u_div_min (
      .clk   (clk),
      .en    (en),
      .bound (box_min_r[a]),
      .orig  (orig[a]),
      .dir   (dir[a]),
      .quot  (t_min[a])
    );
    rbst_slab_div #(.FRAC_BITS(FRAC_BITS)) u_div_max (
      .clk   (clk),
      .en    (en),
      .bound (box_max_r[a]),
      .orig  (orig[a]),
      .dir   (dir[a]),
      .quot  (t_max[a])
    );
  end

  // side data: limits, zero direction handling, direction signs
  side_t side_in;

  always_comb begin
    side_in            = '0;
    side_in.near_limit = in_near_limit;
    side_in.far_limit  = in_far_limit;
    for (int a = 0; a < 3; a++) begin
      side_in.dir_zero[a] = (dir[a] == '0);
      side_in.dir_neg[a]  = dir[a][Q_W-1];
      if ((dir[a] == '0) && ((orig[a] < box_min_r[a]) || (orig[a] > box_max_r[a]))) begin
        side_in.zero_miss = 1'b1;
      end
    end
  end

  side_t side_r  [DIV_LAT];
  logic  valid_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int s = 1; s < DIV_LAT; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_LAT; s++) begin
        valid_r[s] <= 1'b0;
      end
    end else if (en) begin
      valid_r[0] <= in_valid;
      for (int s = 1; s < DIV_LAT; s++) begin
        valid_r[s] <= valid_r[s-1];
      end
    end
  end

  // window narrowing: entry max (at least one LSB) and exit min over the three axes
  side_t side_last;
  q_t    enter [3];
  q_t    leave [3];
  q_t    lo_a;
  q_t    lo_b;
  q_t    hi_a;
  q_t    lo_nxt;
  q_t    hi_nxt;

  assign side_last = side_r[DIV_LAT-1];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (side_last.dir_zero[a]) begin
        enter[a] = Q_ONE_LSB;
        leave[a] = Q_MAX;
      end else if (side_last.dir_neg[a]) begin
        enter[a] = t_max[a];
        leave[a] = t_min[a];
      end else begin
        enter[a] = t_min[a];
        leave[a] = t_max[a];
      end
    end
    lo_a   = (enter[0] > Q_ONE_LSB) ? enter[0] : Q_ONE_LSB;
    lo_b   = (enter[1] > enter[2]) ? enter[1] : enter[2];
    lo_nxt = (lo_a > lo_b) ? lo_a : lo_b;
    hi_a   = (leave[0] < leave[1]) ? leave[0] : leave[1];
    hi_nxt = (hi_a < leave[2]) ? hi_a : leave[2];
  end

  q_t   win_lo_r;
  q_t   win_hi_r;
  q_t   win_near_r;
  q_t   win_far_r;
  logic win_zmiss_r;
  logic win_valid_r;

  always_ff @(posedge clk) begin
    if (en) begin
      win_lo_r    <= lo_nxt;
      win_hi_r    <= hi_nxt;
      win_near_r  <= side_last.near_limit;
      win_far_r   <= side_last.far_limit;
      win_zmiss_r <= side_last.zero_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_valid_r <= 1'b0;
    end else if (en) begin
      win_valid_r <= valid_r[DIV_LAT-1];
    end
  end

  // hit selection against the ray interval
  logic hit_nxt;
  q_t   dist_nxt;
  logic miss;

  always_comb begin
    miss     = win_zmiss_r || (win_hi_r < win_lo_r);
    hit_nxt  = 1'b0;
    dist_nxt = '0;
    if (!miss) begin
      if ((win_lo_r > win_near_r) && (win_lo_r < win_far_r)) begin
        hit_nxt  = 1'b1;
        dist_nxt = win_lo_r;
      end else if ((win_hi_r > win_near_r) && (win_hi_r < win_far_r)) begin
        hit_nxt  = 1'b1;
        dist_nxt = win_hi_r;
      end
    end
  end

  logic hit_r;
  q_t   dist_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= hit_nxt;
      dist_r <= dist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= win_valid_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = hit_r;
  assign out_hit_distance = dist_r;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import rbst_pkg::*;

  localparam int FRAC = 16;
  localparam int N_RAND = 950;

  typedef struct {
    q_t ox, oy, oz, dx, dy, dz, nl, fl;
  } ray_t;

  typedef struct {
    logic hit;
    q_t   distance;
  } hit_t;

  // scoreboard: predicts the slab test and compares results in order
  class slab_scoreboard;
    longint box_lo[3];
    longint box_hi[3];
    hit_t   pending[$];
    int     errors;

    function void set_box(cfg_idx_t idx, q_t v);
      if (idx < CFG_MAX_X) box_lo[idx] = v;
      else box_hi[idx - CFG_MAX_X] = v;
    endfunction

    function longint slab_t(longint bound, longint org, longint d);
      longint q;
      q = ((bound - org) * (64'sd1 <<< FRAC)) / d;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q;
    endfunction

    function void note_ray(ray_t r);
      longint org[3], dv[3];
      longint lo, hi, t0, t1, tmp;
      bit miss;
      hit_t e;
      org = '{r.ox, r.oy, r.oz};
      dv = '{r.dx, r.dy, r.dz};
      lo = 1;
      hi = 64'sd2147483647;
      miss = 0;
      e.hit = 0;
      e.distance = '0;
      for (int a = 0; a < 3; a++) begin
        if (dv[a] == 0) begin
          if (org[a] < box_lo[a] || org[a] > box_hi[a]) miss = 1;
        end else begin
          t0 = slab_t(box_lo[a], org[a], dv[a]);
          t1 = slab_t(box_hi[a], org[a], dv[a]);
          if (dv[a] < 0) begin
            tmp = t0; t0 = t1; t1 = tmp;
          end
          if (t0 > lo) lo = t0;
          if (t1 < hi) hi = t1;
          if (hi < lo) miss = 1;
        end
      end
      if (!miss) begin
        if (lo > longint'(r.nl) && lo < longint'(r.fl)) begin
          e.hit = 1; e.distance = q_t'(lo);
        end else if (hi > longint'(r.nl) && hi < longint'(r.fl)) begin
          e.hit = 1; e.distance = q_t'(hi);
        end
      end
      pending.push_back(e);
    endfunction

    function void check_result(logic hit, q_t distance);
      hit_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result hit=%0b dist=%0d", $time, hit, distance);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (hit !== e.hit) begin
        $display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
        errors++;
      end
      if (distance !== e.distance) begin
        $display("%0t: hit_distance expected %0d actual %0d", $time, e.distance, distance);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  q_t cfg_data;
  logic in_valid, in_ready;
  q_t in_orig_x, in_orig_y, in_orig_z, in_dir_x, in_dir_y, in_dir_z;
  q_t in_near_limit, in_far_limit;
  logic out_valid, out_ready, out_hit;
  q_t out_hit_distance;

  slab_scoreboard sb;
  int send_idle_pct, recv_idle_pct;

  ray_box_slab_test_core u_dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #50ms;
    $display("ray_box_slab_test_core: mismatch");
    $finish;
  end

  // receiver with random stalls, checks every transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_hit, out_hit_distance);
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_box(cfg_idx_t idx, q_t v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_box(idx, v);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic set_box6(q_t x0, q_t y0, q_t z0, q_t x1, q_t y1, q_t z1);
    write_box(CFG_MIN_X, x0); write_box(CFG_MIN_Y, y0); write_box(CFG_MIN_Z, z0);
    write_box(CFG_MAX_X, x1); write_box(CFG_MAX_Y, y1); write_box(CFG_MAX_Z, z1);
  endtask

  // drop valid after the last transfer, then wait for all results
  task automatic wait_drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // valid stays high from one transfer into the next unless the sender idles
  task automatic send_ray(ray_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_orig_x <= r.ox; in_orig_y <= r.oy; in_orig_z <= r.oz;
    in_dir_x <= r.dx; in_dir_y <= r.dy; in_dir_z <= r.dz;
    in_near_limit <= r.nl; in_far_limit <= r.fl;
    do @(posedge clk); while (!in_ready);
    sb.note_ray(r);
  endtask

  function automatic q_t rnd_full();
    case ($urandom_range(5))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      default: return q_t'($urandom);
    endcase
  endfunction

  // small values in units around the box, dir sometimes zero
  function automatic q_t rnd_coord();
    if ($urandom_range(9) == 0) return rnd_full();
    return q_t'($signed($urandom_range(40 << FRAC)) - (20 << FRAC));
  endfunction

  function automatic q_t rnd_dir();
    case ($urandom_range(9))
      0: return '0;
      1: return rnd_full();
      2: return q_t'($signed($urandom_range(64)) - 32);
      default: return q_t'($signed($urandom_range(4 << FRAC)) - (2 << FRAC));
    endcase
  endfunction

  function automatic ray_t rnd_ray();
    ray_t r;
    r.ox = rnd_coord(); r.oy = rnd_coord(); r.oz = rnd_coord();
    r.dx = rnd_dir(); r.dy = rnd_dir(); r.dz = rnd_dir();
    case ($urandom_range(3))
      0: begin r.nl = rnd_full(); r.fl = rnd_full(); end
      1: begin r.nl = Q_MIN; r.fl = Q_MAX; end
      default: begin
        r.nl = q_t'($urandom_range(2 << FRAC));
        r.fl = q_t'($urandom_range(200 << FRAC));
      end
    endcase
    return r;
  endfunction

  task automatic rand_box();
    q_t lo, span;
    if ($urandom_range(7) == 0) begin
      set_box6(rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full());
      return;
    end
    for (int a = 0; a < 3; a++) begin
      lo = rnd_coord();
      span = q_t'($urandom_range(16 << FRAC));
      write_box(cfg_idx_t'(a), lo);
      write_box(cfg_idx_t'(a + 3), lo + span);
    end
  endtask

  initial begin
    ray_t r;
    sb = new();
    for (int a = 0; a < 3; a++) begin
      sb.box_lo[a] = Q_MAX;
      sb.box_hi[a] = Q_MIN;
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0;
    {in_orig_x, in_orig_y, in_orig_z, in_dir_x, in_dir_y, in_dir_z} = '0;
    in_near_limit = '0; in_far_limit = '0;
    out_ready = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset box is empty: always a miss
    send_ray('{0, 0, 0, 1 << FRAC, 0, 0, Q_MIN, Q_MAX});
    send_ray('{0, 0, 0, 0, 0, 0, Q_MIN, Q_MAX});
    wait_drain();

    // two-unit box at origin + 2..4
    set_box6(2 << FRAC, 2 << FRAC, 2 << FRAC, 4 << FRAC, 4 << FRAC, 4 << FRAC);
    // plain hit along each axis with positive dir, and along x with negative dir
    send_ray('{0, 3 << FRAC, 3 << FRAC, 1 << FRAC, 0, 0, Q_MIN, Q_MAX});
    send_ray('{6 << FRAC, 3 << FRAC, 3 << FRAC, -(1 << FRAC), 0, 0, Q_MIN, Q_MAX});
    send_ray('{3 << FRAC, 0, 3 << FRAC, 0, 1 << FRAC, 0, Q_MIN, Q_MAX});
    send_ray('{3 << FRAC, 3 << FRAC, 0, 0, 0, 1 << FRAC, Q_MIN, Q_MAX});
    // zero dir with origin outside slab, and on its bounds
    send_ray('{0, 5 << FRAC, 3 << FRAC, 1 << FRAC, 0, 0, Q_MIN, Q_MAX});
    send_ray('{0, 2 << FRAC, 4 << FRAC, 1 << FRAC, 0, 0, Q_MIN, Q_MAX});
    // origin inside: near behind, reported as one LSB
    send_ray('{3 << FRAC, 3 << FRAC, 3 << FRAC, 1 << FRAC, 1, -1, 0, Q_MAX});
    // near equals limit: exclusive ends
    send_ray('{0, 3 << FRAC, 3 << FRAC, 1 << FRAC, 0, 0, 2 << FRAC, 4 << FRAC});
    send_ray('{0, 3 << FRAC, 3 << FRAC, 1 << FRAC, 0, 0, 5 << FRAC, Q_MAX});
    // saturating quotients: tiny and extreme dirs
    send_ray('{Q_MIN, 3 << FRAC, 3 << FRAC, 1, 0, 0, Q_MIN, Q_MAX});
    send_ray('{Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, -1, Q_MIN, Q_MAX});
    send_ray('{Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX});
    send_ray('{-1, -1, -1, -1, -1, -1, -1, -1});
    // empty window: diverging ray
    send_ray('{0, 0, 3 << FRAC, 1 << FRAC, -(1 << FRAC), 0, Q_MIN, Q_MAX});
    wait_drain();

    // extreme box, then inverted box
    set_box6(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
    send_ray('{0, 0, 0, 1, 1, 1, Q_MIN, Q_MAX});
    send_ray('{Q_MAX, Q_MIN, 0, 0, 0, 0, Q_MIN, Q_MAX});
    wait_drain();
    set_box6(4 << FRAC, 4 << FRAC, 4 << FRAC, 2 << FRAC, 2 << FRAC, 2 << FRAC);
    send_ray('{0, 3 << FRAC, 3 << FRAC, 1 << FRAC, 0, 0, Q_MIN, Q_MAX});
    wait_drain();

    // random phases with different handshake pressure
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 74 : 0;
      recv_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 33 : 0;
      for (int b = 0; b < 8; b++) begin
        rand_box();
        for (int i = 0; i < N_RAND / 24; i++) begin
          r = rnd_ray();
          send_ray(r);
        end
        wait_drain();
      end
    end

    recv_idle_pct = 0;
    wait_drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("ray_box_slab_test_core: match");
    else
      $display("ray_box_slab_test_core: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rbst_pkg.sv
hw/rtl/rbst_slab_div.sv
hw/rtl/ray_box_slab_test_core.sv
tb/sv/tb.sv
